// ===== design/pdh_pkg.sv =====
`default_nettype none
package pdh_pkg;

    // Sizing of the histogram store and coordinate handling.
    localparam int BINS       = 1024;
    localparam int COORD_BITS = 24;
    localparam int BIN_AW     = (BINS > 1) ? $clog2(BINS) : 1;

    // Fixed field widths of the streams.
    localparam int CW      = 24;   // coordinate, box and bin width
    localparam int CNT_W   = 11;   // bin count register
    localparam int RB_W    = 10;   // read bin and bin number fields
    localparam int TOT_W   = 32;   // bin counter
    localparam int OP_W    = 2;
    localparam int CMD_BW  = (BIN_AW > RB_W) ? BIN_AW : RB_W;
    localparam int USED_W  = (BIN_AW + 1 > CNT_W) ? BIN_AW + 1 : CNT_W;

    localparam logic [CW-1:0] COORD_MASK =
        (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << COORD_BITS) - 64'd1);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_BIN_WIDTH = 3'd0;
    localparam logic [2:0] REG_BIN_COUNT = 3'd1;
    localparam logic [2:0] REG_BOX_X     = 3'd2;
    localparam logic [2:0] REG_BOX_Y     = 3'd3;
    localparam logic [2:0] REG_BOX_Z     = 3'd4;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef enum logic [1:0] {
        CMD_INC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CMD_BW-1:0] bin;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0]    bin_width;
        logic [CNT_W-1:0] bin_count;
        logic [CW-1:0]    box_x;
        logic [CW-1:0]    box_y;
        logic [CW-1:0]    box_z;
    } t_cfg;

endpackage
`default_nettype wire

// ===== design/pdh_ram.sv =====
`default_nettype none
module pdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/pdh_fifo.sv =====
`default_nettype none
module pdh_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pdh_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output pdh_pkg::t_cmd      o_cmd,
    output logic               o_empty
);

    pdh_pkg::t_cmd              r_slot [pdh_pkg::QUEUE_DEPTH];
    logic [pdh_pkg::QAW-1:0]    r_wptr;
    logic [pdh_pkg::QAW-1:0]    r_rptr;
    logic [pdh_pkg::QAW:0]      r_count;

    assign o_full  = (r_count == (pdh_pkg::QAW+1)'(pdh_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("command popped from an empty queue");

endmodule
`default_nettype wire

// ===== design/pdh_front.sv =====
`default_nettype none
module pdh_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pdh_pkg::t_cfg                i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [pdh_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [pdh_pkg::CW-1:0]       i_first_x,
    input  wire logic [pdh_pkg::CW-1:0]       i_first_y,
    input  wire logic [pdh_pkg::CW-1:0]       i_first_z,
    input  wire logic [pdh_pkg::CW-1:0]       i_second_x,
    input  wire logic [pdh_pkg::CW-1:0]       i_second_y,
    input  wire logic [pdh_pkg::CW-1:0]       i_second_z,
    input  wire logic [pdh_pkg::RB_W-1:0]     i_read_bin,
    output logic                              o_push,
    output pdh_pkg::t_cmd                     o_cmd,
    input  wire logic                         i_full
);

    localparam int CW  = pdh_pkg::CW;
    localparam int SQW = 2 * CW + 2;     // sum of three squares
    localparam int DW  = CW + 1;         // distance
    localparam int NW  = DW + 2;         // 2d + w
    localparam int RW  = CW + 2;         // divider partial remainder

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SQ   = 5'b00010,
        F_ROOT = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    function automatic logic [CW-1:0] wrap_mag(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b,
                                               input logic [CW-1:0] box);
        logic signed [CW+1:0] t;
        logic signed [CW+2:0] t2;
        logic signed [CW+2:0] bx;
        logic signed [CW+1:0] m;
        t  = $signed({2'b00, a}) - $signed({2'b00, b});
        t2 = $signed({t, 1'b0});
        bx = $signed({3'b000, box});
        if (t2 < -bx) begin
            t = t + $signed({2'b00, box});
        end else if (t2 >= bx) begin
            t = t - $signed({2'b00, box});
        end
        m = (t < 0) ? -t : t;
        return m[CW-1:0];
    endfunction

    t_fstate                     r_state;
    logic [CW-1:0]               r_a [3];
    logic [CW-1:0]               r_b [3];
    logic [CW-1:0]               r_box [3];
    logic [2:0]                  r_step;
    logic [CW-1:0]               r_mag;
    logic [2*CW-1:0]             r_sq;
    logic [SQW-1:0]              r_acc;
    logic [SQW-1:0]              r_rem;
    logic [SQW-1:0]              r_res;
    logic [SQW-1:0]              r_bit;
    logic [NW-1:0]               r_num;
    logic [RW-1:0]               r_part;
    logic [4:0]                  r_cnt;
    logic [pdh_pkg::CMD_BW-1:0]  r_bin;

    logic                        fire;
    logic [SQW-1:0]              n_acc;
    logic [SQW-1:0]              root_try;
    logic [SQW-1:0]              root_next;
    logic [RW-1:0]               div_try;
    logic [RW-1:0]               div_den;
    logic                        div_bit;
    logic [NW-1:0]               n_num;
    logic [pdh_pkg::USED_W-1:0]  used;

    assign o_ready  = (r_state == F_IDLE) && !i_full;
    assign fire     = i_valid && o_ready;
    assign n_acc    = r_acc + SQW'(r_sq);
    assign root_try = r_res + r_bit;
    assign root_next = (r_rem >= root_try) ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign div_try  = {r_part[RW-2:0], r_num[NW-1]};
    assign div_den  = {1'b0, i_cfg.bin_width, 1'b0};
    assign div_bit  = (div_try >= div_den);
    assign n_num    = {r_num[NW-2:0], div_bit};
    assign used = (pdh_pkg::USED_W'(i_cfg.bin_count) > pdh_pkg::USED_W'(pdh_pkg::BINS))
                ? pdh_pkg::USED_W'(pdh_pkg::BINS) : pdh_pkg::USED_W'(i_cfg.bin_count);

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '{kind: pdh_pkg::CMD_INC, bin: r_bin};
        if (fire && (i_opcode == pdh_pkg::OP_READ)) begin
            o_push = 1'b1;
            o_cmd  = '{kind: pdh_pkg::CMD_READ, bin: pdh_pkg::CMD_BW'(i_read_bin)};
        end else if (fire && (i_opcode == pdh_pkg::OP_CLEAR)) begin
            o_push = 1'b1;
            o_cmd  = '{kind: pdh_pkg::CMD_CLEAR, bin: '0};
        end else if ((r_state == F_PUSH) && !i_full) begin
            o_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_a[0]   <= i_first_x & pdh_pkg::COORD_MASK;
            r_a[1]   <= i_first_y & pdh_pkg::COORD_MASK;
            r_a[2]   <= i_first_z & pdh_pkg::COORD_MASK;
            r_b[0]   <= i_second_x & pdh_pkg::COORD_MASK;
            r_b[1]   <= i_second_y & pdh_pkg::COORD_MASK;
            r_b[2]   <= i_second_z & pdh_pkg::COORD_MASK;
            r_box[0] <= i_cfg.box_x;
            r_box[1] <= i_cfg.box_y;
            r_box[2] <= i_cfg.box_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (fire && (i_opcode == pdh_pkg::OP_DEPOSIT)
                        && (i_cfg.bin_width != '0)) begin
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_state <= F_SQ;
                    end
                end
                F_SQ: begin
                    // Three-deep chain: wrap, square, accumulate, one axis a cycle.
                    if (r_step < 3'd3) begin
                        r_mag <= wrap_mag(r_a[r_step[1:0]], r_b[r_step[1:0]],
                                          r_box[r_step[1:0]]);
                    end
                    if ((r_step >= 3'd1) && (r_step <= 3'd3)) begin
                        r_sq <= r_mag * r_mag;
                    end
                    if (r_step >= 3'd2) begin
                        r_acc <= n_acc;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd4) begin
                        r_rem   <= n_acc;
                        r_res   <= '0;
                        r_bit   <= SQW'(1) << (2 * CW);
                        r_state <= F_ROOT;
                    end
                end
                F_ROOT: begin
                    if (r_rem >= root_try) begin
                        r_rem <= r_rem - root_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_part <= div_bit ? (div_try - div_den) : div_try;
                    r_num  <= n_num;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_bin <= pdh_pkg::CMD_BW'(n_num);
                        r_state <= (n_num < NW'(used)) ? F_PUSH : F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
            // Load the divider as the root finishes.
            if ((r_state == F_ROOT) && r_bit[0]) begin
                r_num  <= NW'({root_next, 1'b0}) + NW'(i_cfg.bin_width);
                r_part <= '0;
                r_cnt  <= 5'(NW - 1);
            end
        end
    end

    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_ROOT) |-> $onehot(r_bit))
        else $error("square root step bit lost");

endmodule
`default_nettype wire

// ===== design/pdh_back.sv =====
`default_nettype none
module pdh_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pdh_pkg::t_cmd                i_cmd,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [pdh_pkg::RB_W-1:0]          o_bin_number,
    output logic [pdh_pkg::TOT_W-1:0]         o_bin_total
);

    localparam int AW = pdh_pkg::BIN_AW;

    typedef enum logic [3:0] {
        B_CLR  = 4'b0001,
        B_IDLE = 4'b0010,
        B_INC  = 4'b0100,
        B_RD   = 4'b1000
    } t_bstate;

    t_bstate                     r_state;
    logic [AW-1:0]               r_clr_addr;
    logic [AW-1:0]               r_addr;
    logic                        r_oob;
    logic [pdh_pkg::RB_W-1:0]    r_num;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [pdh_pkg::TOT_W-1:0]   wdata;
    logic [pdh_pkg::TOT_W-1:0]   rdata;
    logic                        can_pop;

    assign can_pop = !i_empty && ((i_cmd.kind != pdh_pkg::CMD_READ) || !o_valid);
    assign o_pop   = (r_state == B_IDLE) && can_pop;

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == B_CLR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == B_INC) begin
            we    = 1'b1;
            wdata = (rdata == '1) ? rdata : rdata + 1'b1;
        end
    end

    pdh_ram #(
        .WIDTH (pdh_pkg::TOT_W),
        .DEPTH (pdh_pkg::BINS),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (AW'(i_cmd.bin)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_clr_addr <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                B_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(pdh_pkg::BINS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_addr <= AW'(i_cmd.bin);
                        r_oob  <= ({1'b0, i_cmd.bin}
                                   >= (pdh_pkg::CMD_BW + 1)'(pdh_pkg::BINS));
                        r_num  <= pdh_pkg::RB_W'(i_cmd.bin);
                        case (i_cmd.kind)
                            pdh_pkg::CMD_INC:   r_state <= B_INC;
                            pdh_pkg::CMD_READ:  r_state <= B_RD;
                            pdh_pkg::CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= B_CLR;
                            end
                            default:            r_state <= B_IDLE;
                        endcase
                    end
                end
                B_INC: begin
                    r_state <= B_IDLE;
                end
                B_RD: begin
                    o_valid      <= 1'b1;
                    o_bin_number <= r_num;
                    o_bin_total  <= r_oob ? '0 : rdata;
                    r_state      <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    a_rd_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD) |-> !o_valid)
        else $error("read result would overwrite a pending result");
    a_inc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_INC) |-> (wdata != '0))
        else $error("bin increment wrote zero");
    a_clr_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLR) |-> !o_pop)
        else $error("command taken during clearing pass");

endmodule
`default_nettype wire

// ===== design/pair_distance_histogram.sv =====
`default_nettype none
// Pair distance histogram engine, Q8.16 fixed point.
// Requests arrive on the slave stream (s_axis_*). A deposit request carries
// two atom positions; the block forms the minimum-image distance, bins it as
// floor((d + w/2) / w) and bumps that bin, saturating. A read request gives
// one result on the master stream (m_axis_*); a clear request zeroes all bins.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata),
// to be used only while the block is idle.
// A front unit accepts and computes; a four-entry command queue feeds a back
// unit that owns the histogram RAM. A deposit occupies the front through
// wrap and squares on one 24x24 multiplier, the bit-pair square root and the
// restoring bin divider, then one push. Reads and clears are pushed to the
// queue in the same cycle they are accepted. In the back an increment reads
// the RAM, then writes it; a read reads the RAM, then loads the output
// register. A clear sweeps the RAM at one bin per cycle over all BINS bins.
// After reset the same sweep runs over all BINS (1024) bins; requests still
// queue in front meanwhile. When the receiver stalls, the result waits in
// the output register and the back stops only at the next read request.
module pair_distance_histogram (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [23:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[1:0], first_x[25:2], first_y[49:26], first_z[73:50],
    // second_x[97:74], second_y[121:98], second_z[145:122],
    // read_bin[155:146], zero fill [159:156]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // bin_number[9:0], bin_total[41:10], zero fill [47:42]
    output logic [47:0]       m_axis_tdata
);

    pdh_pkg::t_cfg  r_cfg;
    pdh_pkg::t_cmd  push_cmd;
    pdh_pkg::t_cmd  pop_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic [pdh_pkg::RB_W-1:0]  bin_number;
    logic [pdh_pkg::TOT_W-1:0] bin_total;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_width <= 24'd65536;
            r_cfg.bin_count <= 11'd1024;
            r_cfg.box_x     <= '1;
            r_cfg.box_y     <= '1;
            r_cfg.box_z     <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pdh_pkg::REG_BIN_WIDTH: r_cfg.bin_width <= i_cfg_wdata;
                pdh_pkg::REG_BIN_COUNT: r_cfg.bin_count <= i_cfg_wdata[10:0];
                pdh_pkg::REG_BOX_X:     r_cfg.box_x     <= i_cfg_wdata;
                pdh_pkg::REG_BOX_Y:     r_cfg.box_y     <= i_cfg_wdata;
                pdh_pkg::REG_BOX_Z:     r_cfg.box_z     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    pdh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_opcode   (s_axis_tdata[1:0]),
        .i_first_x  (s_axis_tdata[25:2]),
        .i_first_y  (s_axis_tdata[49:26]),
        .i_first_z  (s_axis_tdata[73:50]),
        .i_second_x (s_axis_tdata[97:74]),
        .i_second_y (s_axis_tdata[121:98]),
        .i_second_z (s_axis_tdata[145:122]),
        .i_read_bin (s_axis_tdata[155:146]),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    pdh_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    pdh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (pop_cmd),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_bin_number (bin_number),
        .o_bin_total  (bin_total)
    );

    assign m_axis_tdata = {6'b000000, bin_total, bin_number};

endmodule
`default_nettype wire
